// ----- rtl/flowed_text_unwrap_sig_strip_top_macros.svh -----
// assertion macros used by the rtl top
`ifndef FLOWED_TEXT_UNWRAP_SIG_STRIP_TOP_MACROS_SVH
`define FLOWED_TEXT_UNWRAP_SIG_STRIP_TOP_MACROS_SVH

// concurrent check on clk, quiet while reset is asserted
`define FTU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold on a clock edge
`define FTU_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/ftu_pkg.sv -----
// shared types, byte constants and marker table for the flowed text unwrapper
package ftu_pkg;

	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_DASH  = 8'h2D;

	localparam int unsigned MAX_RES = 4;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_QUOTED = 3'd1,
		PH_TEXT   = 3'd2,
		PH_SP     = 3'd3,
		PH_SPNL   = 3'd4,
		PH_SIG    = 3'd5,
		PH_IGNORE = 3'd6
	} phase_t;

	// next state and the words one input byte produces
	typedef struct packed {
		phase_t          phase;
		logic [2:0]      matched;
		logic [2:0]      cnt;
		logic [3:0][7:0] bytes;
	} ftu_step_t;

	// signature marker "-- " then newline
	function automatic logic [7:0] sig_marker_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = CH_DASH;
			2'd1: b = CH_DASH;
			2'd2: b = CH_SPACE;
			2'd3: b = CH_NL;
			default: b = CH_NL;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/flowed_text_unwrap_sig_strip_top.sv -----
// Flowed text unwrapper with signature stripping. A byte is taken into an input register,
// decoded combinationally against the line state, and its zero to four display words are loaded
// into a four-entry result buffer that drains one word per cycle while m_axis_tready is high.
// A byte that gives at most one word passes at one byte per cycle when the output does not stall;
// a byte that gives more words holds the input until its last word leaves the single read port
// of the result buffer. strip_signature resets to 1 and is sampled at each line start.
module flowed_text_unwrap_sig_strip_top
	import ftu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,        // strip_signature
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,     // [7:0] text_byte
	input  logic       s_axis_tlast,     // chunk_end, no effect on decoding
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,     // [7:0] out_byte
	output logic       m_axis_tlast      // out_last
);

	`include "flowed_text_unwrap_sig_strip_top_macros.svh"

	logic            strip_q;
	phase_t          phase_q;
	logic [2:0]      matched_q;
	logic            valid_s1;
	logic [7:0]      text_s1;
	logic [7:0]      buf_q [MAX_RES];
	logic [2:0]      cnt_q;
	logic [1:0]      rd_q;
	ftu_step_t       res;
	logic            pop;
	logic            take_s1;

	ftu_step u_step (
		.phase     (phase_q),
		.matched   (matched_q),
		.strip     (strip_q),
		.text_byte (text_s1),
		.res       (res)
	);

	assign pop     = m_axis_tvalid && m_axis_tready;
	// decoded byte moves on once the buffer is empty or its last word leaves
	assign take_s1 = valid_s1 && (cnt_q == 3'd0 || (cnt_q == 3'd1 && pop));
	assign s_axis_tready = !valid_s1 || take_s1;

	assign m_axis_tvalid = (cnt_q != 3'd0);
	assign m_axis_tdata  = buf_q[rd_q];
	assign m_axis_tlast  = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q <= 1'b1;
		end else if (cfg_we) begin
			strip_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			text_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			matched_q <= 3'd0;
			cnt_q     <= 3'd0;
			rd_q      <= 2'd0;
		end else if (take_s1) begin
			phase_q   <= res.phase;
			matched_q <= res.matched;
			cnt_q     <= res.cnt;
			rd_q      <= 2'd0;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			for (int k = 0; k < MAX_RES; k++) begin
				buf_q[k] <= res.bytes[k];
			end
		end
	end

	`FTU_NEVER(a_cnt_range, cnt_q > 3'd4, "result count beyond buffer depth")
	`FTU_ASSERT(a_rd_in_range, m_axis_tvalid |-> ({1'b0, rd_q} + cnt_q <= 3'd4), "read index past loaded words")
	`FTU_ASSERT(a_sig_matched, phase_q == PH_SIG |-> (matched_q != 3'd0 && matched_q <= 3'd3), "marker count out of range while checking")
	`FTU_ASSERT(a_ignore_silent, (phase_q == PH_IGNORE && take_s1) |=> (cnt_q == 3'd0 && phase_q == PH_IGNORE), "output after signature")

endmodule

// ----- rtl/ftu_step.sv -----
// line decoder: next state and up to four display bytes for one text byte
module ftu_step
	import ftu_pkg::*;
(
	input  phase_t      phase,
	input  logic [2:0]  matched,
	input  logic        strip,
	input  logic [7:0]  text_byte,
	output ftu_step_t   res
);

	phase_t          nxt_phase;
	logic [2:0]      nxt_matched;
	logic [1:0]      pre_n;
	logic [2:0][7:0] pre;
	logic            tail_en;
	phase_t          txt_phase;
	logic            txt_emit;

	// plain text handling of the current byte
	always_comb begin
		if (text_byte == CH_NL) begin
			txt_phase = PH_START;
			txt_emit  = 1'b1;
		end else if (text_byte == CH_SPACE) begin
			txt_phase = PH_SP;
			txt_emit  = 1'b0;
		end else begin
			txt_phase = PH_TEXT;
			txt_emit  = 1'b1;
		end
	end

	always_comb begin
		nxt_phase   = phase;
		nxt_matched = matched;
		pre_n       = 2'd0;
		pre[0]      = sig_marker_byte(2'd0);
		pre[1]      = sig_marker_byte(2'd1);
		pre[2]      = sig_marker_byte(2'd2);
		tail_en     = 1'b0;
		case (phase)
			PH_START: begin
				if (text_byte == CH_GT) begin
					tail_en   = 1'b1;
					nxt_phase = PH_QUOTED;
				end else if (text_byte == CH_SPACE) begin
					// space-stuffing dropped
					nxt_phase = PH_TEXT;
				end else if (strip && text_byte == CH_DASH) begin
					nxt_phase   = PH_SIG;
					nxt_matched = 3'd1;
				end else begin
					if (strip) begin
						nxt_matched = 3'd0;
					end
					nxt_phase = txt_phase;
					tail_en   = txt_emit;
				end
			end
			PH_QUOTED: begin
				tail_en = 1'b1;
				if (text_byte == CH_NL) begin
					nxt_phase = PH_START;
				end
			end
			PH_TEXT: begin
				nxt_phase = txt_phase;
				tail_en   = txt_emit;
			end
			PH_SP: begin
				if (text_byte == CH_NL) begin
					nxt_phase = PH_SPNL;
				end else begin
					pre_n     = 2'd1;
					pre[0]    = CH_SPACE;
					nxt_phase = txt_phase;
					tail_en   = txt_emit;
				end
			end
			PH_SPNL: begin
				if (text_byte == CH_GT) begin
					pre_n     = 2'd1;
					pre[0]    = CH_NL;
					tail_en   = 1'b1;
					nxt_phase = PH_QUOTED;
				end else if (text_byte == CH_NL) begin
					// empty line after soft break: two newlines
					pre_n     = 2'd1;
					pre[0]    = CH_NL;
					tail_en   = 1'b1;
					nxt_phase = PH_START;
				end else begin
					nxt_phase = txt_phase;
					tail_en   = txt_emit;
				end
			end
			PH_SIG: begin
				if (matched > 3'd3) begin
					nxt_phase = PH_IGNORE;
				end else if (text_byte == sig_marker_byte(matched[1:0])) begin
					nxt_matched = matched + 3'd1;
					if (matched == 3'd3) begin
						nxt_phase = PH_IGNORE;
					end
				end else begin
					// replay the matched marker bytes, then the failing byte unless it is a held space
					nxt_matched = 3'd0;
					pre_n       = matched[1:0];
					nxt_phase   = txt_phase;
					tail_en     = txt_emit;
				end
			end
			default: begin
				nxt_phase = PH_IGNORE;
			end
		endcase
	end

	always_comb begin
		res.phase   = nxt_phase;
		res.matched = nxt_matched;
		res.cnt     = {1'b0, pre_n} + {2'b00, tail_en};
		for (int k = 0; k < 3; k++) begin
			res.bytes[k] = (2'(k) < pre_n) ? pre[k] : text_byte;
		end
		res.bytes[3] = text_byte;
	end

endmodule

// ----- sim/flowed_text_unwrap_sig_strip_top_tb.sv -----
// self-checking testbench for the flowed text unwrapper with signature stripping
module flowed_text_unwrap_sig_strip_top_tb;
	import ftu_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 28;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} word_t;

	// directed row: typed rows carry their expected words, the rest use the predictor
	typedef struct packed {
		logic [7:0]      b;
		logic            last;
		logic            typed;
		logic [2:0]      n;
		logic [3:0][7:0] w;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	flowed_text_unwrap_sig_strip_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// predictor state
	phase_t     line_ph = PH_START;
	logic [2:0] mark_cnt = 3'd0;
	logic       strip_sig = 1'b1;
	logic [7:0] made[$];
	logic [7:0] sig_mark [4] = '{CH_DASH, CH_DASH, CH_SPACE, CH_NL};

	word_t      pending_words[$];
	word_t      head_word;
	logic [7:0] line_q[$];
	dir_row_t   dir_tab [25];

	int errors = 0;
	int items_in = 0;
	int words_out = 0;
	int stall_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	function automatic void put_word(input logic [7:0] b);
		if (made.size() < MAX_RES)
			made.push_back(b);
	endfunction

	function automatic void text_in(input logic [7:0] b);
		if (b == CH_NL) begin
			put_word(b);
			line_ph = PH_START;
		end else if (b == CH_SPACE) begin
			line_ph = PH_SP;
		end else begin
			put_word(b);
		end
	endfunction

	// a failed marker replays through the text phases only
	function automatic void replay_in(input logic [7:0] b);
		if (line_ph == PH_SP) begin
			if (b == CH_NL) begin
				line_ph = PH_SPNL;
			end else begin
				put_word(CH_SPACE);
				line_ph = PH_TEXT;
				text_in(b);
			end
		end else begin
			text_in(b);
		end
	endfunction

	function automatic void marker_in(input logic [7:0] b);
		int n;
		n = mark_cnt;
		if (n > 3) begin
			line_ph = PH_IGNORE;
		end else if (b == sig_mark[n]) begin
			mark_cnt = 3'(n + 1);
			if (n == 3)
				line_ph = PH_IGNORE;
		end else begin
			line_ph = PH_TEXT;
			mark_cnt = 3'd0;
			for (int k = 0; k < n; k++)
				replay_in(sig_mark[k]);
			replay_in(b);
		end
	endfunction

	function automatic void line_start_in(input logic [7:0] b);
		if (b == CH_GT) begin
			line_ph = PH_QUOTED;
			put_word(b);
		end else if (b == CH_SPACE) begin
			line_ph = PH_TEXT;
		end else if (strip_sig) begin
			line_ph = PH_SIG;
			mark_cnt = 3'd0;
			marker_in(b);
		end else begin
			line_ph = PH_TEXT;
			text_in(b);
		end
	endfunction

	function automatic void unwrap_byte(input logic [7:0] b);
		made.delete();
		case (line_ph)
			PH_START: line_start_in(b);
			PH_QUOTED: begin
				put_word(b);
				if (b == CH_NL)
					line_ph = PH_START;
			end
			PH_TEXT: text_in(b);
			PH_SP: replay_in(b);
			PH_SPNL: begin
				if (b == CH_GT || b == CH_NL) begin
					put_word(CH_NL);
					line_ph = PH_START;
					line_start_in(b);
				end else begin
					line_ph = PH_TEXT;
					text_in(b);
				end
			end
			PH_SIG: marker_in(b);
			default: line_ph = PH_IGNORE;
		endcase
	endfunction

	function automatic void expect_made();
		foreach (made[k])
			pending_words.push_back('{made[k], k == made.size() - 1});
	endfunction

	function automatic logic [7:0] printable();
		return 8'($urandom_range(33, 126));
	endfunction

	// one line of text with random content, mostly well formed
	function automatic void build_line();
		int kind;
		int len;
		line_q.delete();
		kind = $urandom_range(0, 6);
		len = $urandom_range(1, 6);
		case (kind)
			0, 6: begin
				for (int k = 0; k < len; k++)
					line_q.push_back(printable());
				if (kind == 6 || $urandom_range(1))
					line_q.push_back(CH_SPACE);
				line_q.push_back(CH_NL);
			end
			1: begin
				line_q.push_back(CH_GT);
				for (int k = 0; k < len; k++)
					line_q.push_back($urandom_range(1) ? CH_SPACE : printable());
				line_q.push_back(CH_NL);
			end
			2: begin
				line_q.push_back(CH_SPACE);
				for (int k = 0; k < len; k++)
					line_q.push_back(printable());
				line_q.push_back(CH_NL);
			end
			3: begin
				len = $urandom_range(0, 4);
				for (int k = 0; k < len; k++)
					line_q.push_back(sig_mark[k]);
				if (len < 4) begin
					line_q.push_back(8'($urandom_range(0, 255)));
					line_q.push_back(CH_NL);
				end
			end
			4: line_q.push_back(CH_NL);
			default: begin
				for (int k = 0; k < len; k++)
					line_q.push_back(8'($urandom_range(0, 255)));
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = 0;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		unwrap_byte(b);
		items_in++;
	endtask

	// the block must be idle: all words back and the pipe flushed of word-less bytes
	task automatic write_strip(input logic v);
		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		strip_sig = v;
	endtask

	task automatic random_phase(input int snd_pct, input int rcv_pct, input logic strip,
			input bit do_hold);
		int sent;
		write_strip(strip);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		// long output stall starts together with the sender
		if (do_hold)
			hold_req = 1'b1;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			build_line();
			foreach (line_q[k]) begin
				// keep the signature marker from completing before the last phase
				if (line_ph == PH_SIG && mark_cnt == 3'd3 && line_q[k] == CH_NL)
					line_q[k] = CH_DASH;
				send_byte(line_q[k], 1'($urandom_range(1)));
				expect_made();
				sent++;
			end
		end
	endtask

	initial begin : rx_side
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: out_byte %h out_last %b", m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				head_word = pending_words.pop_front();
				if (m_axis_tdata !== head_word.b) begin
					$error("out_byte: expected %h, got %h", head_word.b, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== head_word.last) begin
					$error("out_last: expected %b, got %b", head_word.last, m_axis_tlast);
					errors++;
				end
				words_out++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		dir_tab = '{
			'{8'h41, 1'b1, 1'b1, 3'd1, 32'h0000_0041},  // 'A' straight after reset
			'{8'h20, 1'b0, 1'b1, 3'd0, 32'h0},          // held space
			'{8'h0A, 1'b1, 1'b0, 3'd0, 32'h0},          // soft break
			'{8'h62, 1'b0, 1'b0, 3'd0, 32'h0},          // joined line
			'{8'h0A, 1'b0, 1'b0, 3'd0, 32'h0},
			'{8'h3E, 1'b1, 1'b0, 3'd0, 32'h0},          // quoted line
			'{8'h20, 1'b0, 1'b0, 3'd0, 32'h0},
			'{8'hFF, 1'b1, 1'b1, 3'd1, 32'h0000_00FF},
			'{8'h0A, 1'b0, 1'b0, 3'd0, 32'h0},
			'{8'h20, 1'b1, 1'b0, 3'd0, 32'h0},          // space-stuffing
			'{8'h2D, 1'b0, 1'b0, 3'd0, 32'h0},
			'{8'h20, 1'b0, 1'b0, 3'd0, 32'h0},
			'{8'h0A, 1'b1, 1'b0, 3'd0, 32'h0},
			'{8'h3E, 1'b0, 1'b0, 3'd0, 32'h0},          // soft break before a quote
			'{8'h0A, 1'b0, 1'b0, 3'd0, 32'h0},
			'{8'h2D, 1'b1, 1'b0, 3'd0, 32'h0},          // partial marker
			'{8'h2D, 1'b0, 1'b0, 3'd0, 32'h0},
			'{8'h20, 1'b1, 1'b0, 3'd0, 32'h0},
			'{8'h00, 1'b0, 1'b1, 3'd4, 32'h0020_2D2D},  // longest replay
			'{8'h0A, 1'b1, 1'b0, 3'd0, 32'h0},
			'{8'h2D, 1'b0, 1'b0, 3'd0, 32'h0},
			'{8'h78, 1'b1, 1'b0, 3'd0, 32'h0},          // short replay
			'{8'h20, 1'b0, 1'b0, 3'd0, 32'h0},
			'{8'h0A, 1'b0, 1'b0, 3'd0, 32'h0},
			'{8'h0A, 1'b1, 1'b0, 3'd0, 32'h0}           // soft break before an empty line
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 51;
		foreach (dir_tab[r]) begin
			send_byte(dir_tab[r].b, dir_tab[r].last);
			if (dir_tab[r].typed) begin
				for (int k = 0; k < dir_tab[r].n; k++)
					pending_words.push_back('{dir_tab[r].w[k], k == dir_tab[r].n - 1});
			end else begin
				expect_made();
			end
		end

		random_phase(23, 51, 1'b0, 1'b0);
		random_phase(51, 23, 1'b1, 1'b0);
		random_phase(0, 0, 1'b0, 1'b1);

		// last: a complete marker, after which nothing comes out
		write_strip(1'b1);
		while (line_ph != PH_START && line_ph != PH_IGNORE) begin
			send_byte(CH_NL, 1'b0);
			expect_made();
		end
		foreach (sig_mark[k]) begin
			send_byte(sig_mark[k], 1'b0);
			expect_made();
		end
		for (int k = 0; k < 8; k++) begin
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
			expect_made();
		end
		s_axis_tvalid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d bytes in, %0d words checked; quoted, stuffed, soft-break and marker lines",
			items_in, words_out);
		$display("with stripping off and on, a long output stall, ending in a swallowed signature");
		if (errors == 0 && pending_words.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
